[hw/rtl/ebml_pkg.sv]
// Shared types, constants and helper functions for the EBML header parser.
package ebml_pkg;

	// Longest accepted ID and size integers, in bytes.
	localparam int unsigned MAX_ID_BYTES   = 4;
	localparam int unsigned MAX_SIZE_BYTES = 8;

	localparam int unsigned ID_W   = 32;
	localparam int unsigned SIZE_W = 56;

	// Result status codes
	localparam logic [2:0] ST_HEADER    = 3'd0;
	localparam logic [2:0] ST_END       = 3'd1;
	localparam logic [2:0] ST_BAD_ID    = 3'd2;
	localparam logic [2:0] ST_BAD_SIZE  = 3'd3;
	localparam logic [2:0] ST_TRUNCATED = 3'd4;

	localparam int unsigned NUM_CONTAINERS = 10;

	localparam logic [ID_W-1:0] CONTAINER_IDS [NUM_CONTAINERS] = '{
		32'h0000_00a0, 32'h1a45_dfa3, 32'h1853_8067, 32'h1549_a966, 32'h1654_ae6b,
		32'h0000_00ae, 32'h1f43_b675, 32'h0000_6d80, 32'h0000_6240, 32'h0000_5034
	};

	typedef enum logic [2:0] {
		PH_ID_FIRST,
		PH_ID_MORE,
		PH_SIZE_FIRST,
		PH_SIZE_MORE,
		PH_SKIP
	} phase_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_stream;
	} in_item_t;

	typedef struct packed {
		logic [ID_W-1:0]   element_id;
		logic [SIZE_W-1:0] payload_length;
		logic              is_container;
		logic [2:0]        status;
	} out_item_t;

	// Zero bits above the first one bit; 8 for a zero byte.
	function automatic logic [3:0] vint_lead(input logic [7:0] b);
		logic [3:0] lead;
		lead = 4'd8;
		for (int i = 0; i < 8; i++) begin
			if (b[i]) begin
				lead = 4'(7 - i);
			end
		end
		return lead;
	endfunction

	function automatic logic is_container_id(input logic [ID_W-1:0] id);
		logic hit;
		hit = 1'b0;
		for (int i = 0; i < NUM_CONTAINERS; i++) begin
			if (CONTAINER_IDS[i] == id) begin
				hit = 1'b1;
			end
		end
		return hit;
	endfunction

endpackage

[hw/rtl/ebml_out_reg.sv]
// Result register: holds one result until the downstream side takes it.
module ebml_out_reg
	import ebml_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      load,
	input  out_item_t load_item,
	output logic      room,
	output logic      valid,
	input  logic      stall,
	output out_item_t item
);

	logic      valid_q;
	out_item_t item_q;

	// Slot is free if empty or drained this cycle
	assign room  = !valid_q || !stall;
	assign valid = valid_q;
	assign item  = item_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (!stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			item_q <= load_item;
		end
	end

endmodule

[hw/rtl/ebml_parse_core.sv]
// Header decode state machine: consumes one byte per fire, yields at most one result.
module ebml_parse_core
	import ebml_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      fire,
	input  in_item_t  item,
	output logic      res_valid,
	output out_item_t res
);

	phase_t            phase_q, phase_d;
	logic [2:0]        left_q, left_d;
	logic [ID_W-1:0]   id_q, id_d;
	logic [SIZE_W-1:0] size_q, size_d;
	logic [SIZE_W-1:0] skip_q, skip_d;
	logic              halted_q, halted_d;

	logic [7:0]        b;
	logic              eos;
	logic [3:0]        lead;
	logic              bad_id;
	logic              bad_size;
	logic [2:0]        left_dec;
	logic [SIZE_W-1:0] size_first;
	logic [SIZE_W-1:0] size_more;
	logic              done;
	logic [SIZE_W-1:0] len;
	logic              cont;

	assign b          = item.data_byte;
	assign eos        = item.end_of_stream;
	assign lead       = vint_lead(b);
	assign bad_id     = lead >= 4'(MAX_ID_BYTES);
	assign bad_size   = lead >= 4'(MAX_SIZE_BYTES);
	assign left_dec   = (left_q != 3'd0) ? left_q - 3'd1 : left_q;
	assign size_first = {{(SIZE_W-8){1'b0}}, b & ~(8'h80 >> lead[2:0])};
	assign size_more  = {size_q[SIZE_W-9:0], b};
	assign cont       = is_container_id(id_q);

	// Header complete on this byte
	always_comb begin
		done = 1'b0;
		len  = size_more;
		if (!halted_q && !eos) begin
			case (phase_q)
				PH_SIZE_FIRST: begin
					done = !bad_size && (lead == 4'd0);
					len  = size_first;
				end
				PH_SIZE_MORE: begin
					done = (left_dec == 3'd0);
					len  = size_more;
				end
				default: begin
					done = 1'b0;
				end
			endcase
		end
	end

	// Next state
	always_comb begin
		phase_d  = phase_q;
		left_d   = left_q;
		id_d     = id_q;
		size_d   = size_q;
		skip_d   = skip_q;
		halted_d = halted_q;
		if (!halted_q) begin
			if (eos) begin
				if (phase_q == PH_ID_FIRST || phase_q == PH_SKIP) begin
					phase_d = PH_ID_FIRST;
					skip_d  = '0;
				end else begin
					halted_d = 1'b1;
				end
			end else begin
				case (phase_q)
					PH_ID_FIRST: begin
						if (bad_id) begin
							halted_d = 1'b1;
						end else begin
							id_d    = {{(ID_W-8){1'b0}}, b};
							size_d  = '0;
							left_d  = lead[2:0];
							phase_d = (lead != 4'd0) ? PH_ID_MORE : PH_SIZE_FIRST;
						end
					end
					PH_ID_MORE: begin
						id_d   = {id_q[ID_W-9:0], b};
						left_d = left_dec;
						if (left_dec == 3'd0) begin
							phase_d = PH_SIZE_FIRST;
						end
					end
					PH_SIZE_FIRST: begin
						if (bad_size) begin
							halted_d = 1'b1;
						end else begin
							size_d  = size_first;
							left_d  = lead[2:0];
							phase_d = PH_SIZE_MORE;
						end
					end
					PH_SIZE_MORE: begin
						size_d = size_more;
						left_d = left_dec;
					end
					PH_SKIP: begin
						if (skip_q <= SIZE_W'(1)) begin
							skip_d  = '0;
							phase_d = PH_ID_FIRST;
						end else begin
							skip_d = skip_q - SIZE_W'(1);
						end
					end
					default: begin
						phase_d = PH_ID_FIRST;
					end
				endcase
				if (done) begin
					if (cont || len == '0) begin
						phase_d = PH_ID_FIRST;
						skip_d  = '0;
					end else begin
						phase_d = PH_SKIP;
						skip_d  = len;
					end
				end
			end
		end
	end

	// Result
	always_comb begin
		res_valid = 1'b0;
		res       = '0;
		if (!halted_q) begin
			if (eos) begin
				res_valid = 1'b1;
				res.status = (phase_q == PH_ID_FIRST || phase_q == PH_SKIP) ?
					ST_END : ST_TRUNCATED;
			end else if (phase_q == PH_ID_FIRST && bad_id) begin
				res_valid  = 1'b1;
				res.status = ST_BAD_ID;
			end else if (phase_q == PH_SIZE_FIRST && bad_size) begin
				res_valid  = 1'b1;
				res.status = ST_BAD_SIZE;
			end else if (done) begin
				res_valid          = 1'b1;
				res.element_id     = id_q;
				res.payload_length = len;
				res.is_container   = cont;
				res.status         = ST_HEADER;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_ID_FIRST;
			left_q   <= '0;
			id_q     <= '0;
			size_q   <= '0;
			skip_q   <= '0;
			halted_q <= 1'b0;
		end else if (fire) begin
			phase_q  <= phase_d;
			left_q   <= left_d;
			id_q     <= id_d;
			size_q   <= size_d;
			skip_q   <= skip_d;
			halted_q <= halted_d;
		end
	end

`ifndef NO_ASSERTIONS
	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		halted_q |=> halted_q)
		else $error("halt cleared without reset");

	a_halt_silent: assert property (@(posedge clk) disable iff (!arst_n)
		halted_q |-> !res_valid)
		else $error("result produced while halted");

	a_skip_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_SKIP |-> skip_q != '0)
		else $error("skipping with zero count");

	a_id_more_left: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_ID_MORE |-> left_q != 3'd0 && left_q < 3'(MAX_ID_BYTES))
		else $error("ID byte count out of range");

	a_err_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.status != ST_HEADER |->
			res.element_id == '0 && res.payload_length == '0 && !res.is_container)
		else $error("non-header result carries header fields");
`endif

endmodule

[hw/rtl/ebml_element_header_parser_unit.sv]
// Top level of the EBML element header parser: input register, decoder, result register.
//
//  channel | direction | handshake                | payload
//  --------+-----------+--------------------------+-----------------------------------
//  byte    | in        | byte_valid / byte_stall  | byte_item (data_byte, end_of_stream)
//  hdr     | out       | hdr_valid  / hdr_stall   | hdr_item (element_id, payload_length,
//          |           |                          |           is_container, status)
//
// Cycles: one byte transfer per cycle sustained while the result register is not full
//   and stalled; the decode state updates once per byte, so a byte goes through the
//   input register and the decoder, and its result is loaded into the result register.
// Reset: arst_n clears the input and result valids and the decode state, including
//   the error halt; after an error nothing else is produced until reset.
// Stalls: hdr_stall holds the result register; the input register then holds its
//   byte only when the result register is full and stalled, and byte_stall follows.
module ebml_element_header_parser_unit
	import ebml_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,

	input  logic      byte_valid,
	output logic      byte_stall,
	input  in_item_t  byte_item,

	output logic      hdr_valid,
	input  logic      hdr_stall,
	output out_item_t hdr_item
);

	logic      valid_s1;
	in_item_t  item_s1;
	logic      room;
	logic      fire;
	logic      res_valid;
	out_item_t res;
	logic      accept;

	// A byte is processed once the result slot can take whatever it yields
	assign fire       = valid_s1 && room;
	assign byte_stall = valid_s1 && !room;
	assign accept     = byte_valid && !byte_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= byte_item;
		end
	end

	ebml_parse_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.item      (item_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	ebml_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (fire && res_valid),
		.load_item (res),
		.room      (room),
		.valid     (hdr_valid),
		.stall     (hdr_stall),
		.item      (hdr_item)
	);

`ifndef NO_ASSERTIONS
	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !room |=> valid_s1 && $stable(item_s1))
		else $error("input register lost a byte while blocked");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		hdr_valid && hdr_stall |-> !(fire && res_valid))
		else $error("result register overwritten while stalled");

	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		byte_stall |-> hdr_valid && hdr_stall)
		else $error("input stalled with free result slot");
`endif

endmodule
